>>> rtl/ffpa_pkg.sv
package ffpa_pkg;

   localparam int PAGE_BYTES_DEF      = 4096;
   localparam int HEADER_BYTES_DEF    = 8;
   localparam int PAGE_HEAD_BYTES_DEF = 16;
   localparam int MAX_BLOCKS_DEF      = 256;

   localparam int ACTION_W = 2;
   localparam int REQ_W    = 13;
   localparam int HANDLE_W = 12;
   localparam int OFFSET_W = 12;
   localparam int STATUS_W = 3;
   localparam int USED_W   = 13;

   localparam logic [ACTION_W-1:0] ACT_OPEN  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] STS_NO_PAGE      = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FULL         = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND    = 3'd3;
   localparam logic [STATUS_W-1:0] STS_ALREADY_FREE = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_CUT
   } state_type;

   typedef struct packed {
      logic [USED_W-1:0]   space_used;
      logic [STATUS_W-1:0] status;
      logic [OFFSET_W-1:0] block_offset;
   } result_type;

endpackage

>>> rtl/ffpa_engine.sv
module ffpa_engine #(
   parameter int PAGE_BYTES      = ffpa_pkg::PAGE_BYTES_DEF,
   parameter int HEADER_BYTES    = ffpa_pkg::HEADER_BYTES_DEF,
   parameter int PAGE_HEAD_BYTES = ffpa_pkg::PAGE_HEAD_BYTES_DEF,
   parameter int MAX_BLOCKS      = ffpa_pkg::MAX_BLOCKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ffpa_pkg::ACTION_W-1:0]   action,
   input  logic [ffpa_pkg::REQ_W-1:0]      request_length,
   input  logic [ffpa_pkg::HANDLE_W-1:0]   handle,
   output logic                            busy,
   output logic                            done,
   output ffpa_pkg::result_type            result
);
   import ffpa_pkg::*;

   localparam int LEN_W   = REQ_W;
   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int END_W   = $clog2(MAX_BLOCKS + 1);
   localparam int POS_W   = $clog2(PAGE_BYTES + HEADER_BYTES + 1);
   localparam int SPACE_W = $clog2(PAGE_BYTES + 1);
   localparam int NEED_W  = $clog2(PAGE_BYTES + HEADER_BYTES + (2 ** REQ_W) + 1);
   localparam int CUT_W   = POS_W + 1;
   localparam int CMP_W   = (POS_W > HANDLE_W) ? POS_W : HANDLE_W;
   localparam int OUT_W   = (SPACE_W > USED_W) ? SPACE_W : USED_W;

   state_type state_ff, state_in;

   logic [ACTION_W-1:0] act_ff, act_in;
   logic [REQ_W-1:0]    req_ff, req_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [END_W-1:0]    i_ff, i_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    freed_ff, freed_in;
   logic [END_W-1:0]    run_start_ff, run_start_in;
   logic                in_run_ff, in_run_in;
   logic [CUT_W-1:0]    cut_ff, cut_in;
   logic [END_W-1:0]    end_ff, end_in;
   logic [SPACE_W-1:0]  space_ff, space_in;
   logic                open_ff, open_in;

   logic [LEN_W:0]      table_mem [MAX_BLOCKS];
   logic [LEN_W:0]      rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [LEN_W:0]      wr_data;

   logic                blk_used;
   logic [LEN_W-1:0]    blk_len;
   logic [POS_W-1:0]    step;
   logic [NEED_W-1:0]   need;
   logic [CMP_W-1:0]    pos_ext;
   logic [OUT_W-1:0]    space_ext;
   logic                at_end;
   logic [OFFSET_W-1:0] res_offset;
   logic [STATUS_W-1:0] res_status;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         end_ff   <= '0;
         space_ff <= '0;
         open_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
         space_ff <= space_in;
         open_ff  <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      req_ff       <= req_in;
      handle_ff    <= handle_in;
      i_ff         <= i_in;
      pos_ff       <= pos_in;
      freed_ff     <= freed_in;
      run_start_ff <= run_start_in;
      in_run_ff    <= in_run_in;
      cut_ff       <= cut_in;
   end

   assign blk_used = rd_data_ff[LEN_W];
   assign blk_len  = rd_data_ff[LEN_W-1:0];
   assign step     = POS_W'(blk_len) + POS_W'(HEADER_BYTES);
   assign need     = NEED_W'(HEADER_BYTES) + NEED_W'(req_ff) + NEED_W'(space_ff);
   assign pos_ext  = CMP_W'(pos_ff);
   assign at_end   = (i_ff == end_ff);
   assign rd_addr  = i_in[IDX_W-1:0];
   assign busy     = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      req_in       = req_ff;
      handle_in    = handle_ff;
      i_in         = i_ff;
      pos_in       = pos_ff;
      freed_in     = freed_ff;
      run_start_in = run_start_ff;
      in_run_in    = in_run_ff;
      cut_in       = cut_ff;
      end_in       = end_ff;
      space_in     = space_ff;
      open_in      = open_ff;
      wr_en        = 1'b0;
      wr_addr      = i_ff[IDX_W-1:0];
      wr_data      = rd_data_ff;
      done         = 1'b0;
      res_offset   = '0;
      res_status   = STS_OK;

      unique case (state_ff)
         ST_IDLE: begin
            i_in = '0;
            if (start) begin
               act_in    = action;
               req_in    = request_length;
               handle_in = handle;
               pos_in    = POS_W'(PAGE_HEAD_BYTES + HEADER_BYTES);
               freed_in  = '0;
               in_run_in = 1'b0;
               if (action == ACT_OPEN) begin
                  open_in  = 1'b1;
                  end_in   = '0;
                  space_in = SPACE_W'(PAGE_HEAD_BYTES);
                  done     = 1'b1;
               end else if (action == ACT_ALLOC || action == ACT_FREE) begin
                  if (!open_ff) begin
                     res_status = STS_NO_PAGE;
                     done       = 1'b1;
                  end else begin
                     state_in = ST_WALK;
                  end
               end else begin
                  done = 1'b1;
               end
            end
         end

         ST_WALK: begin
            if (act_ff == ACT_ALLOC) begin
               if (at_end) begin
                  state_in = ST_IDLE;
                  done     = 1'b1;
                  if (need > NEED_W'(PAGE_BYTES) || end_ff == END_W'(MAX_BLOCKS)) begin
                     open_in    = 1'b0;
                     end_in     = '0;
                     space_in   = '0;
                     res_status = STS_FULL;
                  end else begin
                     space_in   = SPACE_W'(need);
                     wr_en      = 1'b1;
                     wr_addr    = end_ff[IDX_W-1:0];
                     wr_data    = {1'b1, req_ff};
                     end_in     = end_ff + END_W'(1);
                     res_offset = pos_ext[OFFSET_W-1:0];
                  end
               end else if (!blk_used && req_ff <= blk_len) begin
                  state_in   = ST_IDLE;
                  done       = 1'b1;
                  wr_en      = 1'b1;
                  wr_data    = {1'b1, blk_len};
                  res_offset = pos_ext[OFFSET_W-1:0];
               end else begin
                  pos_in = pos_ff + step;
                  i_in   = i_ff + END_W'(1);
               end
            end else begin
               if (at_end) begin
                  state_in   = ST_IDLE;
                  done       = 1'b1;
                  res_status = STS_NOT_FOUND;
               end else if (pos_ext == CMP_W'(handle_ff)) begin
                  if (!blk_used) begin
                     state_in   = ST_IDLE;
                     done       = 1'b1;
                     res_status = STS_ALREADY_FREE;
                  end else if (i_ff + END_W'(1) == end_ff) begin
                     state_in = ST_CUT;
                     cut_in   = CUT_W'(step) + (in_run_ff ? CUT_W'(freed_ff) : '0);
                     end_in   = in_run_ff ? run_start_ff : i_ff;
                  end else begin
                     state_in = ST_IDLE;
                     done     = 1'b1;
                     wr_en    = 1'b1;
                     wr_data  = {1'b0, blk_len};
                  end
               end else begin
                  if (!blk_used) begin
                     if (!in_run_ff) begin
                        in_run_in    = 1'b1;
                        run_start_in = i_ff;
                        freed_in     = step;
                     end else begin
                        freed_in = freed_ff + step;
                     end
                  end else begin
                     in_run_in = 1'b0;
                     freed_in  = '0;
                  end
                  pos_in = pos_ff + step;
                  i_in   = i_ff + END_W'(1);
               end
            end
         end

         ST_CUT: begin
            state_in = ST_IDLE;
            done     = 1'b1;
            if (cut_ff <= CUT_W'(space_ff)) begin
               space_in = SPACE_W'(CUT_W'(space_ff) - cut_ff);
            end else begin
               space_in = '0;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign space_ext = open_in ? OUT_W'(space_in) : '0;

   always_comb begin
      result.block_offset = res_offset;
      result.status       = res_status;
      result.space_used   = space_ext[USED_W-1:0];
   end

endmodule

>>> rtl/first_fit_page_allocator_top.sv
// First-fit page allocator. Each request transfer gives exactly one response
// transfer. Open, unknown actions and any request while no page is open answer
// in the cycle after the transfer. Allocate and free walk the block table one
// entry per cycle through its single read port, and a free that trims the page
// end passes through a further cut state. The block takes no new request while
// a walk runs, and it takes the next one in the same cycle the pending response
// is transferred. The table needs no clearing after reset.
module first_fit_page_allocator_top #(
   parameter int PAGE_BYTES      = ffpa_pkg::PAGE_BYTES_DEF,
   parameter int HEADER_BYTES    = ffpa_pkg::HEADER_BYTES_DEF,
   parameter int PAGE_HEAD_BYTES = ffpa_pkg::PAGE_HEAD_BYTES_DEF,
   parameter int MAX_BLOCKS      = ffpa_pkg::MAX_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // request_length[12:0], handle[24:13], zero fill
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // block_offset[11:0], status[14:12], space_used[27:15]
);
   import ffpa_pkg::*;

   logic       engine_busy;
   logic       engine_done;
   result_type engine_result;
   logic       accept;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   assign req_tready = !engine_busy && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   ffpa_engine #(
      .PAGE_BYTES      (PAGE_BYTES),
      .HEADER_BYTES    (HEADER_BYTES),
      .PAGE_HEAD_BYTES (PAGE_HEAD_BYTES),
      .MAX_BLOCKS      (MAX_BLOCKS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .start          (accept),
      .action         (req_tuser[ACTION_W-1:0]),
      .request_length (req_tdata[REQ_W-1:0]),
      .handle         (req_tdata[REQ_W+HANDLE_W-1:REQ_W]),
      .busy           (engine_busy),
      .done           (engine_done),
      .result         (engine_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (engine_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = engine_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

endmodule

>>> tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ffpa_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 750;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 600;

   class page_scoreboard;
      bit          block_used[MAX_BLOCKS_DEF];
      int unsigned block_len[MAX_BLOCKS_DEF];
      int unsigned block_count;
      int unsigned bytes_used;
      bit          page_is_open;
      result_type  expected_q[$];
      int          errors;

      function int unsigned payload_offset(int unsigned idx);
         int unsigned pos;
         pos = PAGE_HEAD_BYTES_DEF + HEADER_BYTES_DEF;
         for (int unsigned i = 0; i < idx; i++) begin
            pos += block_len[i] + HEADER_BYTES_DEF;
         end
         return pos;
      endfunction

      function void push_result(int unsigned offset, logic [STATUS_W-1:0] sts);
         result_type r;
         r.block_offset = offset[OFFSET_W-1:0];
         r.status       = sts;
         r.space_used   = page_is_open ? bytes_used[USED_W-1:0] : '0;
         expected_q.push_back(r);
      endfunction

      function void allocate(int unsigned len);
         int unsigned pos;
         int          hit;
         hit = -1;
         pos = PAGE_HEAD_BYTES_DEF + HEADER_BYTES_DEF;
         for (int unsigned i = 0; i < block_count && hit < 0; i++) begin
            if (!block_used[i] && len <= block_len[i]) begin
               hit = i;
            end else begin
               pos += block_len[i] + HEADER_BYTES_DEF;
            end
         end
         if (hit >= 0) begin
            block_used[hit] = 1'b1;
            push_result(pos, STS_OK);
         end else if (HEADER_BYTES_DEF + len + bytes_used > PAGE_BYTES_DEF ||
                      block_count >= MAX_BLOCKS_DEF) begin
            page_is_open = 1'b0;
            block_count  = 0;
            bytes_used   = 0;
            push_result(0, STS_FULL);
         end else begin
            bytes_used = HEADER_BYTES_DEF + len + bytes_used;
            block_used[block_count] = 1'b1;
            block_len[block_count]  = len;
            block_count++;
            push_result(pos, STS_OK);
         end
      endfunction

      function void release_block(int unsigned hnd);
         int unsigned pos, run_start, run_bytes, cut;
         bit          in_run;
         int          hit;
         hit       = -1;
         pos       = PAGE_HEAD_BYTES_DEF + HEADER_BYTES_DEF;
         run_start = 0;
         run_bytes = 0;
         in_run    = 1'b0;
         for (int unsigned i = 0; i < block_count && hit < 0; i++) begin
            if (pos == hnd) begin
               hit = i;
            end else begin
               if (!block_used[i]) begin
                  if (!in_run) begin
                     in_run    = 1'b1;
                     run_start = i;
                     run_bytes = 0;
                  end
                  run_bytes += block_len[i] + HEADER_BYTES_DEF;
               end else begin
                  in_run    = 1'b0;
                  run_bytes = 0;
               end
               pos += block_len[i] + HEADER_BYTES_DEF;
            end
         end
         if (hit < 0) begin
            push_result(0, STS_NOT_FOUND);
         end else if (!block_used[hit]) begin
            push_result(0, STS_ALREADY_FREE);
         end else begin
            if (hit + 1 == block_count) begin
               // Freeing the last block trims the page end back over any free run before it.
               cut = block_len[hit] + HEADER_BYTES_DEF;
               if (in_run) begin
                  cut += run_bytes;
                  block_count = run_start;
               end else begin
                  block_count = hit;
               end
               bytes_used = (cut <= bytes_used) ? bytes_used - cut : 0;
            end else begin
               block_used[hit] = 1'b0;
            end
            push_result(0, STS_OK);
         end
      endfunction

      function void note_request(logic [ACTION_W-1:0] act, logic [REQ_W-1:0] len,
                                 logic [HANDLE_W-1:0] hnd);
         if (act == ACT_OPEN) begin
            page_is_open = 1'b1;
            block_count  = 0;
            bytes_used   = PAGE_HEAD_BYTES_DEF;
            push_result(0, STS_OK);
         end else if (act == ACT_ALLOC || act == ACT_FREE) begin
            if (!page_is_open) begin
               push_result(0, STS_NO_PAGE);
            end else if (act == ACT_ALLOC) begin
               allocate(len);
            end else begin
               release_block(hnd);
            end
         end else begin
            push_result(0, STS_OK);
         end
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("response with no request pending: %h", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.block_offset !== want.block_offset) begin
            $error("block_offset expected %0d actual %0d", want.block_offset, got.block_offset);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
         end
         if (got.space_used !== want.space_used) begin
            $error("space_used expected %0d actual %0d", want.space_used, got.space_used);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   page_scoreboard sb = new();
   int          sent_count;
   int          burst_left;
   int unsigned cycle_count;

   first_fit_page_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL first_fit_page_allocator_top");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(result_type'(rsp_tdata[27:0]));
      end
   end

   task automatic issue_request(input logic [ACTION_W-1:0] act,
                                input logic [REQ_W-1:0] len,
                                input logic [HANDLE_W-1:0] hnd);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'd0, hnd, len};
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, len, hnd);
      sent_count++;
   endtask

   function automatic logic [REQ_W-1:0] pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return REQ_W'($urandom_range(0, 64));
      if (r < 90) return REQ_W'($urandom_range(65, 512));
      if (r < 98) return REQ_W'($urandom_range(513, 4095));
      return REQ_W'(PAGE_BYTES_DEF);
   endfunction

   function automatic logic [HANDLE_W-1:0] pick_handle();
      int unsigned r;
      int unsigned pos;
      r = $urandom_range(0, 99);
      if (r < 75 && sb.block_count > 0) begin
         pos = sb.payload_offset($urandom_range(0, sb.block_count - 1));
      end else if (r < 88) begin
         pos = sb.payload_offset(sb.block_count);
      end else begin
         pos = $urandom_range(0, 4095);
      end
      return pos[HANDLE_W-1:0];
   endfunction

   task automatic random_request();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!sb.page_is_open && r < 85) begin
         issue_request(ACT_OPEN, REQ_W'($urandom), HANDLE_W'($urandom));
      end else if (r < 45) begin
         issue_request(ACT_ALLOC, pick_length(), HANDLE_W'($urandom));
      end else if (r < 88) begin
         issue_request(ACT_FREE, REQ_W'($urandom), pick_handle());
      end else if (r < 93) begin
         issue_request(ACT_UNUSED, REQ_W'($urandom), HANDLE_W'($urandom));
      end else begin
         issue_request(ACT_OPEN, REQ_W'($urandom), HANDLE_W'($urandom));
      end
   endtask

   initial begin
      int         hold_left;
      int         span;
      int         mode;
      bit         hold_done;
      logic       ready_next;
      hold_left = 0;
      span      = 0;
      mode      = 0;
      hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(20, 200);
               if (!hold_done && sent_count >= 400) begin
                  hold_done = 1'b1;
                  hold_left = HOLD_CYCLES;
               end
            end else begin
               span--;
            end
            case (mode)
               0: ready_next = 1'b1;
               1: ready_next = 1'($urandom_range(0, 1));
               2: ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = ($urandom_range(0, 3) != 0);
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_OPEN;
      sent_count = 0;
      burst_left = 0;
      cycle_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      issue_request(ACT_ALLOC, 13'd5, '0);
      issue_request(ACT_FREE, '0, 12'd24);
      issue_request(ACT_UNUSED, '0, '0);
      issue_request(ACT_OPEN, '0, '0);
      issue_request(ACT_ALLOC, 13'd0, '0);
      issue_request(ACT_ALLOC, 13'd100, '0);
      issue_request(ACT_ALLOC, 13'd50, '0);
      issue_request(ACT_FREE, '0, HANDLE_W'(sb.payload_offset(1)));
      issue_request(ACT_FREE, '0, HANDLE_W'(sb.payload_offset(1)));
      issue_request(ACT_ALLOC, 13'd80, '0);
      issue_request(ACT_FREE, '0, HANDLE_W'(sb.payload_offset(sb.block_count)));
      issue_request(ACT_FREE, '0, 12'hFFF);
      issue_request(ACT_FREE, '0, 12'h000);
      issue_request(ACT_UNUSED, 13'h1FFF, 12'hFFF);
      issue_request(ACT_FREE, '0, HANDLE_W'(sb.payload_offset(1)));
      issue_request(ACT_FREE, '0, HANDLE_W'(sb.payload_offset(2)));
      issue_request(ACT_OPEN, '0, '0);
      issue_request(ACT_ALLOC,
                    REQ_W'(PAGE_BYTES_DEF - PAGE_HEAD_BYTES_DEF - HEADER_BYTES_DEF), '0);
      issue_request(ACT_ALLOC, 13'd0, '0);
      issue_request(ACT_FREE, '0, 12'd24);
      issue_request(ACT_OPEN, '0, '0);
      issue_request(ACT_ALLOC, REQ_W'(PAGE_BYTES_DEF), '0);
      issue_request(ACT_OPEN, '0, '0);
      issue_request(ACT_ALLOC, 13'd4095, '0);

      // Fill every table entry with short blocks, then ask for one more.
      issue_request(ACT_OPEN, '0, '0);
      while (sb.page_is_open && sb.block_count < MAX_BLOCKS_DEF) begin
         if ($urandom_range(0, 9) == 0) begin
            issue_request(ACT_FREE, '0, pick_handle());
         end else begin
            issue_request(ACT_ALLOC, REQ_W'($urandom_range(0, 3)), '0);
         end
      end
      issue_request(ACT_ALLOC, REQ_W'($urandom_range(0, 3)), '0);

      while (sent_count < ITEM_TARGET) begin
         random_request();
      end
      req_tvalid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (MAX_BLOCKS_DEF + 8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS first_fit_page_allocator_top");
      end else begin
         $display("FAIL first_fit_page_allocator_top");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/ffpa_pkg.sv
rtl/ffpa_engine.sv
rtl/first_fit_page_allocator_top.sv
tb/testbench.sv
